// File: hw/rtl/ipdd_pkg.sv
// ----------------------------------------------------------------------------
// ipdd_pkg
// Shared types and constants for the IR pulse-distance decoder.
// ----------------------------------------------------------------------------
package ipdd_pkg;

	localparam int GAP_W   = 20;
	localparam int CODE_W  = 8;
	localparam int CNT_W   = 6;
	localparam int INDEX_W = 3;

	// Register map of the configuration port
	typedef enum logic [INDEX_W-1:0] {
		REG_START_MIN = 3'd0,
		REG_START_MAX = 3'd1,
		REG_ONE_MIN   = 3'd2,
		REG_ONE_MAX   = 3'd3,
		REG_ON_CODE   = 3'd4,
		REG_OFF_CODE  = 3'd5
	} reg_index_t;

	localparam logic [GAP_W-1:0]  START_MIN_RST = 20'd10000;
	localparam logic [GAP_W-1:0]  START_MAX_RST = 20'd14000;
	localparam logic [GAP_W-1:0]  ONE_MIN_RST   = 20'd2000;
	localparam logic [GAP_W-1:0]  ONE_MAX_RST   = 20'd2300;
	localparam logic [CODE_W-1:0] ON_CODE_RST   = 8'd70;
	localparam logic [CODE_W-1:0] OFF_CODE_RST  = 8'd69;

	// Input item kind
	localparam logic KIND_EDGE    = 1'b0;
	localparam logic KIND_TIMEOUT = 1'b1;

	typedef enum logic [1:0] {
		ACT_NONE = 2'd0,
		ACT_ON   = 2'd1,
		ACT_OFF  = 2'd2
	} led_action_t;

	typedef struct packed {
		logic [GAP_W-1:0]  start_min;
		logic [GAP_W-1:0]  start_max;
		logic [GAP_W-1:0]  one_min;
		logic [GAP_W-1:0]  one_max;
		logic [CODE_W-1:0] on_code;
		logic [CODE_W-1:0] off_code;
	} cfg_t;

	typedef struct packed {
		logic              frame_ok;
		logic [CODE_W-1:0] command;
		led_action_t       led_action;
	} result_t;

	typedef struct packed {
		logic             armed;
		logic [CNT_W-1:0] edge_count;
	} frame_status_t;

endpackage

// File: hw/rtl/ipdd_cfg_regs.sv
// ----------------------------------------------------------------------------
// ipdd_cfg_regs
// Configuration register file: window limits and LED command codes.
// ----------------------------------------------------------------------------
module ipdd_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ipdd_pkg::INDEX_W-1:0]  cfg_index,
	input  logic [ipdd_pkg::GAP_W-1:0]    cfg_data,
	output ipdd_pkg::cfg_t                cfg
);

	ipdd_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_min <= ipdd_pkg::START_MIN_RST;
			cfg_q.start_max <= ipdd_pkg::START_MAX_RST;
			cfg_q.one_min   <= ipdd_pkg::ONE_MIN_RST;
			cfg_q.one_max   <= ipdd_pkg::ONE_MAX_RST;
			cfg_q.on_code   <= ipdd_pkg::ON_CODE_RST;
			cfg_q.off_code  <= ipdd_pkg::OFF_CODE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (ipdd_pkg::reg_index_t'(cfg_index))
				ipdd_pkg::REG_START_MIN: cfg_q.start_min <= cfg_data;
				ipdd_pkg::REG_START_MAX: cfg_q.start_max <= cfg_data;
				ipdd_pkg::REG_ONE_MIN:   cfg_q.one_min   <= cfg_data;
				ipdd_pkg::REG_ONE_MAX:   cfg_q.one_max   <= cfg_data;
				ipdd_pkg::REG_ON_CODE:   cfg_q.on_code   <= cfg_data[ipdd_pkg::CODE_W-1:0];
				ipdd_pkg::REG_OFF_CODE:  cfg_q.off_code  <= cfg_data[ipdd_pkg::CODE_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// File: hw/rtl/ipdd_frame.sv
// ----------------------------------------------------------------------------
// ipdd_frame
// Frame state: arming, edge slot counter, start gap and command bits, plus
// the timeout verdict built from that state.
// ----------------------------------------------------------------------------
module ipdd_frame #(
	parameter int FRAME_DEPTH    = 50,
	parameter int FIRST_BIT_SLOT = 17
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  logic                        kind,
	input  logic [ipdd_pkg::GAP_W-1:0]  gap_us,
	input  ipdd_pkg::cfg_t              cfg,
	output ipdd_pkg::result_t           result,
	output ipdd_pkg::frame_status_t     status
);

	localparam logic [ipdd_pkg::CNT_W-1:0] DEPTH_C  = ipdd_pkg::CNT_W'(FRAME_DEPTH);
	localparam logic [ipdd_pkg::CNT_W-1:0] FIRST_C  = ipdd_pkg::CNT_W'(FIRST_BIT_SLOT);
	localparam logic [ipdd_pkg::CNT_W-1:0] PAST_C   =
		ipdd_pkg::CNT_W'(FIRST_BIT_SLOT + ipdd_pkg::CODE_W);

	logic                          armed_q;
	logic [ipdd_pkg::CNT_W-1:0]    edge_count_q;
	logic [ipdd_pkg::GAP_W-1:0]    start_gap_q;
	logic [ipdd_pkg::CODE_W-1:0]   bit_store_q;

	logic                          slot_open;
	logic                          in_bit_slot;
	logic                          is_one;
	logic [ipdd_pkg::CNT_W-1:0]    bit_offset;
	logic [2:0]                    bit_sel;
	logic                          ok;

	assign slot_open   = armed_q && (edge_count_q < DEPTH_C);
	assign in_bit_slot = (edge_count_q >= FIRST_C) && (edge_count_q < PAST_C);
	assign is_one      = (gap_us >= cfg.one_min) && (gap_us <= cfg.one_max);
	assign bit_offset  = edge_count_q - FIRST_C;
	assign bit_sel     = bit_offset[2:0];

	// Verdict for a timeout, from the state left by all earlier items
	always_comb begin
		ok              = (start_gap_q >= cfg.start_min) && (start_gap_q <= cfg.start_max);
		result.frame_ok = ok;
		result.command  = ok ? bit_store_q : '0;
		if (!ok) begin
			result.led_action = ipdd_pkg::ACT_NONE;
		end else if (bit_store_q == cfg.on_code) begin
			result.led_action = ipdd_pkg::ACT_ON;
		end else if (bit_store_q == cfg.off_code) begin
			result.led_action = ipdd_pkg::ACT_OFF;
		end else begin
			result.led_action = ipdd_pkg::ACT_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q      <= 1'b0;
			edge_count_q <= '0;
			start_gap_q  <= '0;
			bit_store_q  <= '0;
		end else if (fire) begin
			if (kind == ipdd_pkg::KIND_TIMEOUT) begin
				// disarm; command bits carry over to the next frame
				armed_q      <= 1'b0;
				edge_count_q <= '0;
				start_gap_q  <= '0;
			end else if (!armed_q) begin
				armed_q <= 1'b1;
			end else if (slot_open) begin
				if (edge_count_q == '0) begin
					start_gap_q <= gap_us;
				end
				if (in_bit_slot) begin
					bit_store_q[bit_sel] <= is_one;
				end
				edge_count_q <= edge_count_q + 1'b1;
			end
		end
	end

	assign status.armed      = armed_q;
	assign status.edge_count = edge_count_q;

endmodule

// File: hw/rtl/ir_pulse_distance_decoder_unit.sv
// Timing: a timeout beat is loaded into the input register when it is accepted
// and into the result register once the output is free, where it raises
// out_valid; edge beats give no result.
// Throughput: one beat per cycle while the output is not stalled; the frame
// state update is a range compare and bit write between the two registers.
// Reset: arst_n clears the pipeline valids and the frame state and loads the
// register defaults; no clearing pass.
// ----------------------------------------------------------------------------
// ir_pulse_distance_decoder_unit
// Pulse-distance IR command decoder: edge gaps in, command byte and LED action
// out on each frame timeout.
// ----------------------------------------------------------------------------
module ir_pulse_distance_decoder_unit #(
	parameter int FRAME_DEPTH    = 50,
	parameter int FIRST_BIT_SLOT = 17
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ipdd_pkg::INDEX_W-1:0]  cfg_index,
	input  logic [ipdd_pkg::GAP_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          kind,
	input  logic [ipdd_pkg::GAP_W-1:0]    gap_us,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          frame_ok,
	output logic [ipdd_pkg::CODE_W-1:0]   command,
	output logic [1:0]                    led_action
);

	ipdd_pkg::cfg_t                cfg;
	ipdd_pkg::result_t             result;
	ipdd_pkg::frame_status_t       status;

	logic                          valid_s1;
	logic                          kind_s1;
	logic [ipdd_pkg::GAP_W-1:0]    gap_s1;
	logic                          out_valid_q;
	ipdd_pkg::result_t             result_q;
	logic                          out_free;
	logic                          fire_s1;
	logic                          in_accept;

	assign out_free  = !out_valid_q || !out_stall;
	assign fire_s1   = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign in_accept = in_valid && !in_stall;

	ipdd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			kind_s1 <= kind;
			gap_s1  <= gap_us;
		end
	end

	ipdd_frame #(
		.FRAME_DEPTH    (FRAME_DEPTH),
		.FIRST_BIT_SLOT (FIRST_BIT_SLOT)
	) u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire_s1),
		.kind   (kind_s1),
		.gap_us (gap_s1),
		.cfg    (cfg),
		.result (result),
		.status (status)
	);

	// result register; hold while the beat is stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fire_s1 && (kind_s1 == ipdd_pkg::KIND_TIMEOUT);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			result_q <= result;
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_ok   = result_q.frame_ok;
	assign command    = result_q.command;
	assign led_action = result_q.led_action;

	a_edge_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && (kind_s1 == ipdd_pkg::KIND_EDGE) |=> !out_valid)
		else $error("edge beat produced a result");

	a_timeout_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && (kind_s1 == ipdd_pkg::KIND_TIMEOUT) |=> out_valid)
		else $error("timeout beat lost its result");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		status.edge_count <= ipdd_pkg::CNT_W'(FRAME_DEPTH))
		else $error("edge counter past frame depth");

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		!status.armed |-> (status.edge_count == '0))
		else $error("edges counted while not armed");

endmodule
